// ===== hdl/energy_meter_frame_scaler_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the energy meter frame scaler
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef ENERGY_METER_FRAME_SCALER_UNIT_ASSERT_SVH
`define ENERGY_METER_FRAME_SCALER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define EMFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define EMFS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/emfs_pkg.sv =====
// ---------------------------------------------------------------------------
// emfs_pkg
// Types and constants shared by the energy meter frame scaler modules.
// ---------------------------------------------------------------------------
`default_nettype none

package emfs_pkg;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [19:0] MAX20 = 20'hFFFFF;
	localparam logic [31:0] MAX32 = 32'hFFFFFFFF;
	localparam logic [47:0] MAX48 = 48'hFFFFFFFFFFFF;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLTAGE_ZERO_OFFSET = 3'd0,
		REG_VOLTAGE_GAIN        = 3'd1,
		REG_VOLTAGE_FLOOR_MV    = 3'd2,
		REG_PIN_GAIN            = 3'd3,
		REG_PIN_FLOOR_UV        = 3'd4,
		REG_CURRENT_GAIN        = 3'd5,
		REG_CURRENT_FLOOR_MA    = 3'd6,
		REG_ENERGY_GAIN         = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [23:0] voltage_zero_offset;
		logic [31:0] voltage_gain;
		logic [19:0] voltage_floor_mv;
		logic [31:0] pin_gain;
		logic [19:0] pin_floor_uv;
		logic [31:0] current_gain;
		logic [19:0] current_floor_ma;
		logic [31:0] energy_gain;
	} cfg_t;

	// Outcome of the pulse counter update.
	typedef enum logic [1:0] {
		CNT_COUNTED = 2'd0,
		CNT_PRIMED  = 2'd1,
		CNT_WRAPPED = 2'd2,
		CNT_NONPOS  = 2'd3
	} cnt_status_t;

	// Operand pair selected for the shared multiplier.
	typedef enum logic [1:0] {
		MUL_VOLT   = 2'd0,
		MUL_PIN    = 2'd1,
		MUL_CUR    = 2'd2,
		MUL_ENERGY = 2'd3
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VOLT,
		ST_PIN,
		ST_PIN_SAT,
		ST_CUR,
		ST_ENERGY,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     load;
		logic     clear;
		logic     eval;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     mv_en;
		logic     pin_en;
		logic     ma_en;
		logic     acc_en;
		logic     out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic action;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/emfs_cfg.sv =====
// ---------------------------------------------------------------------------
// emfs_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module emfs_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [emfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [emfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output emfs_pkg::cfg_t                         cfg
);

	emfs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (emfs_pkg::cfg_idx_t'(cfg_index))
				emfs_pkg::REG_VOLTAGE_ZERO_OFFSET: cfg_q.voltage_zero_offset <= cfg_wdata[23:0];
				emfs_pkg::REG_VOLTAGE_GAIN:        cfg_q.voltage_gain        <= cfg_wdata;
				emfs_pkg::REG_VOLTAGE_FLOOR_MV:    cfg_q.voltage_floor_mv    <= cfg_wdata[19:0];
				emfs_pkg::REG_PIN_GAIN:            cfg_q.pin_gain            <= cfg_wdata;
				emfs_pkg::REG_PIN_FLOOR_UV:        cfg_q.pin_floor_uv        <= cfg_wdata[19:0];
				emfs_pkg::REG_CURRENT_GAIN:        cfg_q.current_gain        <= cfg_wdata;
				emfs_pkg::REG_CURRENT_FLOOR_MA:    cfg_q.current_floor_ma    <= cfg_wdata[19:0];
				emfs_pkg::REG_ENERGY_GAIN:         cfg_q.energy_gain         <= cfg_wdata;
				default:                           cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/emfs_ctrl.sv =====
// ---------------------------------------------------------------------------
// emfs_ctrl
// Sequencer that steps one frame through the shared-multiplier datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module emfs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire emfs_pkg::dp_sts_t  sts,
	output emfs_pkg::ctl_cmd_t      cmd
);

	emfs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= emfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			emfs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = emfs_pkg::ST_VOLT;
				end
			end
			emfs_pkg::ST_VOLT: begin
				if (sts.action) begin
					cmd.clear = 1'b1;
					state_d   = emfs_pkg::ST_IDLE;
				end else begin
					cmd.eval    = 1'b1;
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = emfs_pkg::MUL_VOLT;
					state_d     = emfs_pkg::ST_PIN;
				end
			end
			emfs_pkg::ST_PIN: begin
				cmd.mv_en   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = emfs_pkg::MUL_PIN;
				state_d     = emfs_pkg::ST_PIN_SAT;
			end
			emfs_pkg::ST_PIN_SAT: begin
				cmd.pin_en = 1'b1;
				state_d    = emfs_pkg::ST_CUR;
			end
			emfs_pkg::ST_CUR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = emfs_pkg::MUL_CUR;
				state_d     = emfs_pkg::ST_ENERGY;
			end
			emfs_pkg::ST_ENERGY: begin
				cmd.ma_en   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = emfs_pkg::MUL_ENERGY;
				state_d     = emfs_pkg::ST_ACC;
			end
			emfs_pkg::ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = emfs_pkg::ST_DONE;
			end
			emfs_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = emfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = emfs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/emfs_dp.sv =====
// ---------------------------------------------------------------------------
// emfs_dp
// Datapath: word capture, pulse counter logic, shared 32x32 multiplier,
// saturation and floors, energy accumulator and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module emfs_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire emfs_pkg::cfg_t      cfg,
	input  wire emfs_pkg::ctl_cmd_t  cmd,
	output emfs_pkg::dp_sts_t        sts,
	input  wire logic                action,
	input  wire logic [23:0]         voltage_raw,
	input  wire logic [23:0]         current_raw,
	input  wire logic signed [31:0]  pulse_count_a,
	input  wire logic signed [31:0]  pulse_count_b,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [19:0]              voltage_mv,
	output logic [19:0]              current_ma,
	output logic [47:0]              energy_total,
	output logic [1:0]               counter_status
);

	// Captured word.
	logic        action_q;
	logic [23:0] vraw_q;
	logic [23:0] iraw_q;
	logic [31:0] ca_q;
	logic [31:0] cb_q;

	// Counter state.
	logic        primed_q;
	logic [31:0] last_a_q;
	logic [31:0] last_b_q;
	logic [47:0] acc_q;
	logic [31:0] sum_q;
	emfs_pkg::cnt_status_t status_q;

	// Multiplier and intermediate results.
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_d;
	logic [63:0] prod_q;
	logic [31:0] pin_q;
	logic [19:0] mv_q;
	logic [19:0] ma_q;

	// Output register.
	logic        out_valid_q;
	logic [19:0] out_mv_q;
	logic [19:0] out_ma_q;
	logic [47:0] out_energy_q;
	logic [1:0]  out_status_q;

	logic [23:0] corr;
	logic [31:0] da;
	logic [31:0] db;
	logic [31:0] dsum;
	logic        cross_a;
	logic        cross_b;
	logic [35:0] mv_raw;
	logic [35:0] pin_raw;
	logic [31:0] pin_sat;
	logic [43:0] ma_raw;
	logic [48:0] acc_sum;

	function automatic logic crossed(input logic [31:0] cur, input logic [31:0] prev);
		logic [31:0] d;
		logic        d_pos;
		d     = cur - prev;
		d_pos = !d[31] && (d != 32'd0);
		return (!prev[31] && cur[31] && d[31]) || (prev[31] && !cur[31] && d_pos);
	endfunction

	assign corr    = (vraw_q > cfg.voltage_zero_offset) ?
		(vraw_q - cfg.voltage_zero_offset) : 24'd0;
	assign da      = ca_q - last_a_q;
	assign db      = cb_q - last_b_q;
	assign dsum    = da + db;
	assign cross_a = crossed(ca_q, last_a_q);
	assign cross_b = crossed(cb_q, last_b_q);

	always_comb begin
		case (cmd.mul_sel)
			emfs_pkg::MUL_VOLT: begin
				mul_a = {8'd0, corr};
				mul_b = cfg.voltage_gain;
			end
			emfs_pkg::MUL_PIN: begin
				mul_a = {8'd0, iraw_q};
				mul_b = cfg.pin_gain;
			end
			emfs_pkg::MUL_CUR: begin
				mul_a = pin_q;
				mul_b = cfg.current_gain;
			end
			default: begin
				mul_a = sum_q;
				mul_b = cfg.energy_gain;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// Scaled values from the registered product.
	assign mv_raw  = prod_q[55:20];
	assign pin_raw = prod_q[55:20];
	assign ma_raw  = prod_q[63:20];
	assign pin_sat = (pin_raw[35:32] != 4'd0) ? emfs_pkg::MAX32 : pin_raw[31:0];
	assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q[63:16]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			vraw_q   <= voltage_raw;
			iraw_q   <= current_raw;
			ca_q     <= unsigned'(pulse_count_a);
			cb_q     <= unsigned'(pulse_count_b);
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.mv_en) begin
			if (mv_raw < {16'd0, cfg.voltage_floor_mv}) begin
				mv_q <= 20'd0;
			end else if (mv_raw[35:20] != 16'd0) begin
				mv_q <= emfs_pkg::MAX20;
			end else begin
				mv_q <= mv_raw[19:0];
			end
		end
		if (cmd.pin_en) begin
			pin_q <= (pin_sat < {12'd0, cfg.pin_floor_uv}) ? 32'd0 : pin_sat;
		end
		if (cmd.ma_en) begin
			if (ma_raw < {24'd0, cfg.current_floor_ma}) begin
				ma_q <= 20'd0;
			end else if (ma_raw[43:20] != 24'd0) begin
				ma_q <= emfs_pkg::MAX20;
			end else begin
				ma_q <= ma_raw[19:0];
			end
		end
		if (cmd.eval) begin
			sum_q <= dsum;
			if (!primed_q) begin
				status_q <= emfs_pkg::CNT_PRIMED;
			end else if (cross_a || cross_b) begin
				status_q <= emfs_pkg::CNT_WRAPPED;
			end else if (dsum == 32'd0 || dsum[31]) begin
				status_q <= emfs_pkg::CNT_NONPOS;
			end else begin
				status_q <= emfs_pkg::CNT_COUNTED;
			end
		end
		if (cmd.out_load) begin
			out_mv_q     <= mv_q;
			out_ma_q     <= ma_q;
			out_energy_q <= acc_q;
			out_status_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q    <= 1'b0;
			last_a_q    <= '0;
			last_b_q    <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				primed_q <= 1'b0;
				last_a_q <= '0;
				last_b_q <= '0;
				acc_q    <= '0;
			end else if (cmd.eval) begin
				primed_q <= 1'b1;
				last_a_q <= ca_q;
				last_b_q <= cb_q;
			end
			if (cmd.acc_en && status_q == emfs_pkg::CNT_COUNTED) begin
				acc_q <= acc_sum[48] ? emfs_pkg::MAX48 : acc_sum[47:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.action   = action_q;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid      = out_valid_q;
	assign voltage_mv     = out_mv_q;
	assign current_ma     = out_ma_q;
	assign energy_total   = out_energy_q;
	assign counter_status = out_status_q;

endmodule

`default_nettype wire

// ===== hdl/energy_meter_frame_scaler_unit.sv =====
// A frame word walks four products through the one shared 32x32 multiplier, and the input
// is not free again until its result is loaded, which waits while the output register is
// busy; a clear word gives no result and frees the input once the counts are cleared.
// A finished result waits in the output register while the next word is taken in.
// Reset (arst_n low, asynchronous) clears the configuration, the controller, both stored
// counts, the energy total and the output valid flag, and leaves the counters unprimed.
// ---------------------------------------------------------------------------
// energy_meter_frame_scaler_unit
// Scales raw RMS voltage and current of a metering frame to millivolts and
// milliamps, and folds pulse counter deltas into a saturating energy total.
// ---------------------------------------------------------------------------
`default_nettype none

module energy_meter_frame_scaler_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write port.
	input  wire logic                            cfg_we,
	input  wire logic [emfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [emfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// Input word.
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            action,
	input  wire logic [23:0]                     voltage_raw,
	input  wire logic [23:0]                     current_raw,
	input  wire logic signed [31:0]              pulse_count_a,
	input  wire logic signed [31:0]              pulse_count_b,
	// Result word.
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [19:0]                          voltage_mv,
	output logic [19:0]                          current_ma,
	output logic [47:0]                          energy_total,
	output logic [1:0]                           counter_status
);

	// The controller issues one command per cycle. The datapath captures the
	// word on load; for a clear word the next step zeroes the total and the
	// stored counts and returns to idle. For a frame word the multiplier forms,
	// in turn, the voltage product, the pin product, the current product from
	// the floored pin value, and the energy increment. The counter decision is
	// made alongside the voltage product, and the increment is added only for
	// a counted frame. The result word is loaded once the output register is
	// free, so a waiting result that is not taken blocks the next word.

	emfs_pkg::cfg_t     cfg;
	emfs_pkg::ctl_cmd_t cmd;
	emfs_pkg::dp_sts_t  sts;

	emfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	emfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	emfs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.voltage_raw    (voltage_raw),
		.current_raw    (current_raw),
		.pulse_count_a  (pulse_count_a),
		.pulse_count_b  (pulse_count_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.voltage_mv     (voltage_mv),
		.current_ma     (current_ma),
		.energy_total   (energy_total),
		.counter_status (counter_status)
	);

endmodule

`default_nettype wire

// ===== hdl/emfs_checker.sv =====
// ---------------------------------------------------------------------------
// emfs_checker
// Port-level checks of the energy meter frame scaler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "energy_meter_frame_scaler_unit_assert.svh"

module emfs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        action,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [47:0] energy_total,
	input wire logic [1:0]  counter_status
);

	// Only one word is in work at a time.
	`EMFS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while a word is in work")

	// A clear word never produces a result.
	`EMFS_ASSERT_NEXT(a_clear_silent, in_valid && in_ready && action, !$rose(out_valid), "clear word produced a result")

	// A stalled result word stays valid and holds its energy total and counter status.
	`EMFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(energy_total) && $stable(counter_status), "stalled result word changed")

	// A result appears only after an accepted word.
	`EMFS_ASSERT_NEXT(a_out_needs_work, in_ready && !out_valid, !$rose(out_valid), "result word without an accepted word")

endmodule

bind energy_meter_frame_scaler_unit emfs_checker u_emfs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.action         (action),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.energy_total   (energy_total),
	.counter_status (counter_status)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the energy meter frame scaler. A software copy of
// the scaling and pulse counting logic predicts every reading word, and the
// bench compares each word that leaves the block against the oldest
// prediction while both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

	// One reading word as it leaves the block.
	typedef struct packed {
		logic [19:0]           voltage_mv;
		logic [19:0]           current_ma;
		logic [47:0]           energy_total;
		emfs_pkg::cnt_status_t counter_status;
	} reading_t;

	// Mirror of the scaler: its registers, its pulse counter state and the
	// readings it still owes. Frames are folded in at the moment the block
	// takes them, so the queue order matches the order of the output words.
	class meter_frame_tracker;
		logic [23:0] v_offset = '0;
		logic [31:0] v_gain   = '0;
		logic [19:0] v_floor  = '0;
		logic [31:0] p_gain   = '0;
		logic [19:0] p_floor  = '0;
		logic [31:0] c_gain   = '0;
		logic [19:0] c_floor  = '0;
		logic [31:0] e_gain   = '0;

		logic [31:0] last_a      = '0;
		logic [31:0] last_b      = '0;
		bit          primed      = 1'b0;
		logic [47:0] energy_acc  = '0;

		reading_t    owed_readings[$];
		int unsigned mismatch_count = 0;

		function void set_register(emfs_pkg::cfg_idx_t idx, logic [31:0] val);
			case (idx)
				emfs_pkg::REG_VOLTAGE_ZERO_OFFSET: v_offset = val[23:0];
				emfs_pkg::REG_VOLTAGE_GAIN:        v_gain   = val;
				emfs_pkg::REG_VOLTAGE_FLOOR_MV:    v_floor  = val[19:0];
				emfs_pkg::REG_PIN_GAIN:            p_gain   = val;
				emfs_pkg::REG_PIN_FLOOR_UV:        p_floor  = val[19:0];
				emfs_pkg::REG_CURRENT_GAIN:        c_gain   = val;
				emfs_pkg::REG_CURRENT_FLOOR_MA:    c_floor  = val[19:0];
				default:                           e_gain   = val;
			endcase
		endfunction

		// The floor is tested on the unsaturated value, then the result clips.
		function logic [19:0] clip_with_floor(logic [63:0] v, logic [19:0] fl);
			if (v < {44'd0, fl})
				return 20'd0;
			if (v > {44'd0, emfs_pkg::MAX20})
				return emfs_pkg::MAX20;
			return v[19:0];
		endfunction

		// A counter that changes sign against the direction of its delta has
		// wrapped or been reloaded, so the frame cannot be trusted.
		function bit sign_crossed(logic [31:0] cur, logic [31:0] prev);
			logic [31:0] d;
			d = cur - prev;
			return (!prev[31] && cur[31] && d[31]) ||
				(prev[31] && !cur[31] && !d[31] && d != 32'd0);
		endfunction

		function emfs_pkg::cnt_status_t fold_pulses(logic [31:0] ca, logic [31:0] cb);
			logic [31:0] da;
			logic [31:0] db;
			logic [31:0] total;
			logic [63:0] sum64;
			if (!primed) begin
				last_a = ca;
				last_b = cb;
				primed = 1'b1;
				return emfs_pkg::CNT_PRIMED;
			end
			if (sign_crossed(ca, last_a) || sign_crossed(cb, last_b)) begin
				last_a = ca;
				last_b = cb;
				return emfs_pkg::CNT_WRAPPED;
			end
			da = ca - last_a;
			db = cb - last_b;
			last_a = ca;
			last_b = cb;
			total = da + db;
			if (total == 32'd0 || total[31])
				return emfs_pkg::CNT_NONPOS;
			sum64 = {16'd0, energy_acc} + (({32'd0, total} * {32'd0, e_gain}) >> 16);
			energy_acc = (sum64 > {16'd0, emfs_pkg::MAX48}) ? emfs_pkg::MAX48 : sum64[47:0];
			return emfs_pkg::CNT_COUNTED;
		endfunction

		function void note_word(logic act, logic [23:0] vraw, logic [23:0] iraw,
			logic [31:0] ca, logic [31:0] cb);
			reading_t    r;
			logic [23:0] corr;
			logic [63:0] pin;
			if (act) begin
				energy_acc = '0;
				last_a = '0;
				last_b = '0;
				primed = 1'b0;
				return;
			end
			r.counter_status = fold_pulses(ca, cb);
			corr = (vraw > v_offset) ? vraw - v_offset : 24'd0;
			r.voltage_mv = clip_with_floor(({40'd0, corr} * {32'd0, v_gain}) >> 20, v_floor);
			pin = ({40'd0, iraw} * {32'd0, p_gain}) >> 20;
			if (pin > {32'd0, emfs_pkg::MAX32})
				pin = {32'd0, emfs_pkg::MAX32};
			if (pin < {44'd0, p_floor})
				pin = 64'd0;
			r.current_ma = clip_with_floor((pin * {32'd0, c_gain}) >> 20, c_floor);
			r.energy_total = energy_acc;
			owed_readings.push_back(r);
		endfunction

		function void check_result(reading_t got);
			reading_t want;
			if (owed_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected reading: mv=%0d ma=%0d energy=%0d status=%0d",
						got.voltage_mv, got.current_ma, got.energy_total, got.counter_status);
				return;
			end
			want = owed_readings.pop_front();
			if (got.voltage_mv !== want.voltage_mv || got.current_ma !== want.current_ma ||
				got.energy_total !== want.energy_total ||
				got.counter_status !== want.counter_status) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("reading mismatch: expected mv=%0d ma=%0d energy=%0d status=%0d,",
						want.voltage_mv, want.current_ma, want.energy_total,
						want.counter_status,
						" got mv=%0d ma=%0d energy=%0d status=%0d",
						got.voltage_mv, got.current_ma,
						got.energy_total, got.counter_status);
			end
		endfunction

		function int unsigned owed(); 
			return owed_readings.size();
		endfunction
	endclass

	logic                            clk            = 1'b0;
	logic                            arst_n         = 1'b0;
	logic                            cfg_we         = 1'b0;
	logic [emfs_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [emfs_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;
	logic                            in_valid       = 1'b0;
	logic                            in_ready;
	logic                            action         = 1'b0;
	logic [23:0]                     voltage_raw    = '0;
	logic [23:0]                     current_raw    = '0;
	logic signed [31:0]              pulse_count_a  = '0;
	logic signed [31:0]              pulse_count_b  = '0;
	logic                            out_valid;
	logic                            out_ready      = 1'b0;
	logic [19:0]                     voltage_mv;
	logic [19:0]                     current_ma;
	logic [47:0]                     energy_total;
	logic [1:0]                      counter_status;

	meter_frame_tracker tracker = new();

	// Readings taken so far; the sink pacing uses it to place its long hold-offs.
	int unsigned readings_taken = 0;

	// Running pulse counters of the simulated metering chip.
	logic [31:0] chip_count_a = '0;
	logic [31:0] chip_count_b = '0;

	energy_meter_frame_scaler_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.voltage_raw    (voltage_raw),
		.current_raw    (current_raw),
		.pulse_count_a  (pulse_count_a),
		.pulse_count_b  (pulse_count_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.voltage_mv     (voltage_mv),
		.current_ma     (current_ma),
		.energy_total   (energy_total),
		.counter_status (counter_status)
	);

	always #10 clk = ~clk;

	// Offers one word from a rising edge and returns at the edge that takes it.
	// The handshake is sampled at the falling edge, where every signal is
	// settled, and the word is noted in the tracker just before it is taken.
	task automatic send_word(input logic act, input logic [23:0] vraw,
		input logic [23:0] iraw, input logic [31:0] ca, input logic [31:0] cb);
		in_valid      <= 1'b1;
		action        <= act;
		voltage_raw   <= vraw;
		current_raw   <= iraw;
		pulse_count_a <= ca;
		pulse_count_b <= cb;
		do
			@(negedge clk);
		while (!in_ready);
		tracker.note_word(act, vraw, iraw, ca, cb);
		@(posedge clk);
	endtask

	task automatic write_register(input emfs_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		tracker.set_register(idx, val);
		@(posedge clk);
	endtask

	// A clear word leaves nothing to wait for, so after the last reading the
	// block may still be busy, and the wait runs on past the last reading.
	task automatic wait_for_idle();
		while (tracker.owed() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Register value for one phase. Style 0 is a plausible calibration,
	// 1 puts every register at its top, 2 drives all gains to the top with
	// the offset and floors at zero, and 3 picks per register among typical, top, zero and random.
	function automatic logic [31:0] pick_setting(input emfs_pkg::cfg_idx_t idx,
		input int unsigned style);
		logic [31:0] mask;
		logic [31:0] typical;
		bit          is_gain;
		int unsigned sel;
		is_gain = 1'b0;
		case (idx)
			emfs_pkg::REG_VOLTAGE_ZERO_OFFSET: begin
				mask = 32'h00FFFFFF;
				typical = $urandom_range(0, 200000);
			end
			emfs_pkg::REG_VOLTAGE_GAIN, emfs_pkg::REG_PIN_GAIN,
			emfs_pkg::REG_CURRENT_GAIN: begin
				mask = emfs_pkg::MAX32;
				typical = $urandom_range(1 << 16, 1 << 22);
				is_gain = 1'b1;
			end
			emfs_pkg::REG_ENERGY_GAIN: begin
				mask = emfs_pkg::MAX32;
				typical = $urandom_range(1 << 8, 1 << 20);
				is_gain = 1'b1;
			end
			default: begin
				mask = {12'd0, emfs_pkg::MAX20};
				typical = $urandom_range(0, 5000);
			end
		endcase
		if (style == 2)
			return is_gain ? mask : 32'd0;
		sel = (style == 3) ? $urandom_range(0, 3) : style;
		case (sel)
			0: return typical;
			1: return mask;
			2: return 32'd0;
			default: return $urandom & mask;
		endcase
	endfunction

	task automatic apply_settings(input int unsigned style);
		wait_for_idle();
		for (int i = 0; i < 8; i++)
			write_register(emfs_pkg::cfg_idx_t'(i),
				pick_setting(emfs_pkg::cfg_idx_t'(i), style));
		cfg_we <= 1'b0;
	endtask

	// Raw RMS value: mostly random, over the full range or a small one, sometimes close to
	// a reference point such as the zero offset, sometimes at the ends.
	function automatic logic [23:0] pick_raw(input logic [23:0] ref_point);
		logic [23:0] v;
		case ($urandom_range(0, 9))
			0: v = 24'd0;
			1: v = 24'hFFFFFF;
			2, 3: v = ref_point + 24'($urandom_range(0, 2047)) - 24'd1024;
			4, 5: v = 24'($urandom_range(0, 4095));
			default: v = 24'($urandom);
		endcase
		return v;
	endfunction

	// Moves the simulated chip counters. Most frames count up by a small
	// amount as a real meter would; the rest jump to random values, park
	// just below a sign boundary so that later frames cross it, run
	// backwards, or stand still.
	task automatic advance_chip_counters(input int unsigned pick);
		if (pick < 8) begin
			chip_count_a = $urandom;
			chip_count_b = $urandom;
		end else if (pick < 13) begin
			if ($urandom_range(0, 1))
				chip_count_a = ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'hFFFFFFFF)
					- $urandom_range(0, 50);
			else
				chip_count_b = ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'hFFFFFFFF)
					- $urandom_range(0, 50);
		end else if (pick < 18) begin
			chip_count_a = chip_count_a - $urandom_range(0, 500);
			chip_count_b = chip_count_b + $urandom_range(0, 200);
		end else if (pick >= 22) begin
			chip_count_a = chip_count_a + (($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 32'h00FFFFFF) : $urandom_range(0, 3000));
			chip_count_b = chip_count_b + (($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 32'h00FFFFFF) : $urandom_range(0, 3000));
		end
	endtask

	// Random frames in bursts of random length separated by random gaps, so
	// the gaps land on every step of the block's walk through a frame.
	task automatic run_random_frames(input int unsigned count);
		int unsigned burst;
		int unsigned pick;
		burst = $urandom_range(1, 40);
		for (int unsigned n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			advance_chip_counters(pick);
			send_word(pick < 3, pick_raw(tracker.v_offset), pick_raw(24'd2048),
				chip_count_a, chip_count_b);
			burst--;
			if (burst == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
				burst = $urandom_range(1, 40);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Every accepted reading is checked against the oldest prediction. The
	// falling edge sees the handshake that the next rising edge completes.
	always @(negedge clk) begin : reading_monitor
		reading_t got;
		if (arst_n && out_valid && out_ready) begin
			got.voltage_mv     = voltage_mv;
			got.current_ma     = current_ma;
			got.energy_total   = energy_total;
			got.counter_status = emfs_pkg::cnt_status_t'(counter_status);
			tracker.check_result(got);
			readings_taken++;
		end
	end

	// The reading sink stalls in stretches of its own: always ready, ready
	// half the time, seldom ready, or alternating. Twice it holds off for a
	// long stretch while frames keep coming, so the result register and the
	// datapath fill and the block has to drop in_ready.
	initial begin : sink_pacing
		int unsigned mode;
		int unsigned left;
		int unsigned hold_at;
		mode = 0;
		left = 0;
		hold_at = 250;
		forever begin
			@(posedge clk);
			if (readings_taken >= hold_at) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_at = (hold_at == 250) ? 1100 : 32'hFFFFFFFF;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(8, 80);
			end
			left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 4) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With every register still at zero all scaled values are zero; the
		// first frame only primes the counters and a clear follows.
		send_word(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'd0, 32'd0);
		send_word(1'b1, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		in_valid <= 1'b0;

		// Unity gains with small offsets and floors make every threshold
		// easy to hit exactly.
		wait_for_idle();
		write_register(emfs_pkg::REG_VOLTAGE_ZERO_OFFSET, 32'd1000);
		write_register(emfs_pkg::REG_VOLTAGE_GAIN, 32'd1 << 20);
		write_register(emfs_pkg::REG_VOLTAGE_FLOOR_MV, 32'd500);
		write_register(emfs_pkg::REG_PIN_GAIN, 32'd1 << 20);
		write_register(emfs_pkg::REG_PIN_FLOOR_UV, 32'd100);
		write_register(emfs_pkg::REG_CURRENT_GAIN, 32'd1 << 20);
		write_register(emfs_pkg::REG_CURRENT_FLOOR_MA, 32'd150);
		write_register(emfs_pkg::REG_ENERGY_GAIN, 32'd1 << 16);
		cfg_we <= 1'b0;

		// Prime, then count; voltage just under its floor, pin just under its floor.
		send_word(1'b0, 24'd0, 24'd0, 32'd100, 32'd200);
		send_word(1'b0, 24'd1499, 24'd99, 32'd150, 32'd260);
		// Zero delta; voltage exactly at its floor, current under its floor.
		send_word(1'b0, 24'd1500, 24'd120, 32'd150, 32'd260);
		// Negative delta sum; voltage below the offset clamps to zero.
		send_word(1'b0, 24'd500, 24'd150, 32'd100, 32'd300);
		// Largest positive jump; both outputs saturate.
		send_word(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'h7FFFFFFF, 32'd300);
		// Counting up through the sign boundary is an ordinary count.
		send_word(1'b0, 24'h800000, 24'h000001, 32'h80000005, 32'd300);
		// Going back below the boundary is only a negative delta.
		send_word(1'b0, 24'h7FFFFF, 24'hAAAAAA, 32'h7FFFFFF0, 32'd300);
		// Non-negative to negative with a negative delta is discarded.
		send_word(1'b0, 24'h555555, 24'h123456, 32'hFFFFFFF0, 32'd300);
		// Negative to non-negative with a positive delta is discarded too.
		send_word(1'b0, 24'hAAAAAA, 24'h654321, 32'h00000010, 32'd300);
		// The same on channel B alone.
		send_word(1'b0, 24'd1000, 24'd0, 32'h00000010, 32'hFFFFFFFB);
		send_word(1'b0, 24'd1001, 24'd1, 32'h00000010, 32'hFFFFFFFB);
		// Clear, then prime and count from negative counter values.
		send_word(1'b1, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_word(1'b0, 24'd2000, 24'd300, -32'd100, -32'd200);
		send_word(1'b0, 24'd2000, 24'd300, -32'd50, -32'd150);
		in_valid <= 1'b0;

		// Every register at its top: the energy total saturates within a few
		// frames, the pin stage saturates, and the floors swallow the rest.
		apply_settings(1);
		send_word(1'b1, 24'd0, 24'd0, 32'd0, 32'd0);
		send_word(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'd0, 32'd0);
		send_word(1'b0, 24'd0, 24'h000001, 32'h7FFFFFFF, 32'd0);
		send_word(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_word(1'b0, 24'd0, 24'd0, 32'hFFFFFFFE, 32'h7FFFFFFF);
		send_word(1'b0, 24'd0, 24'd0, 32'hFFFFFFFF, 32'h7FFFFFFF);
		in_valid <= 1'b0;

		// Random traffic under a series of register settings.
		apply_settings(0);
		run_random_frames(322);
		apply_settings(1);
		run_random_frames(322);
		apply_settings(2);
		run_random_frames(322);
		for (int p = 0; p < 3; p++) begin
			apply_settings(3);
			run_random_frames(322);
		end

		wait_for_idle();
		if (tracker.mismatch_count == 0 && tracker.owed() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, including both long
	// hold-offs of the sink.
	initial begin : watchdog
		#10000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
